// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the crank/wheel generator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define CWSG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the condition
`define CWSG_ASSERT_NEXT(label, cond, prop, msg) \
    `CWSG_ASSERT(label, (cond) |=> (prop), msg)

`endif

// ----- design/cwsg_pkg.sv -----
// ---------------------------------------------------------------------------
// cwsg_pkg
// Shared types, constants and helper functions of the crank/wheel generator.
// ---------------------------------------------------------------------------
package cwsg_pkg;

    // Field widths
    localparam int RPM_W     = 15;
    localparam int KMH_W     = 10;
    localparam int RSTEP_W   = 10;
    localparam int SSTEP_W   = 6;
    localparam int WCONST_W  = 32;
    localparam int PAT_W     = 60;
    localparam int TIME_W    = 32;
    localparam int CMP_W     = 16;
    localparam int PRE_W     = 10;
    localparam int IDX_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 60;

    // Divider operand widths: 2*wheel_constant+kmh needs 34 bits,
    // 2*prescale*rpm needs at most 27 bits
    localparam int DIVIDEND_W = 34;
    localparam int DIVISOR_W  = 27;

    localparam logic [DIVIDEND_W-1:0] CLOCK_HZ = 34'd16000000;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_ENCODER = 2'd1,
        FUNC_BUTTON  = 2'd2
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RPM_STEP    = 3'd0,
        REG_RPM_LIMIT   = 3'd1,
        REG_SPEED_STEP  = 3'd2,
        REG_SPEED_LIMIT = 3'd3,
        REG_WHEEL_CONST = 3'd4,
        REG_PAT_LOW     = 3'd5,
        REG_PAT_HIGH    = 3'd6
    } cfg_reg_t;

    // Step direction codes (down is -1 in two bits)
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd3;

    // Divider status back to the sequencer
    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_result_t;

    // Step a setpoint in the given direction, clamp to 0..limit
    function automatic logic [RPM_W-1:0] clamp_step(
        input logic [RPM_W-1:0]   value,
        input logic [RSTEP_W-1:0] step,
        input logic [1:0]         dir,
        input logic [RPM_W-1:0]   limit
    );
        logic [RPM_W:0] n;
        n = {1'b0, value};
        if (dir == DIR_UP) begin
            n = {1'b0, value} + (RPM_W+1)'(step);
        end else if (dir == DIR_DOWN) begin
            n = ((RPM_W+1)'(step) > {1'b0, value}) ? '0
                                                   : {1'b0, value} - (RPM_W+1)'(step);
        end
        if (n > {1'b0, limit}) begin
            n = {1'b0, limit};
        end
        return n[RPM_W-1:0];
    endfunction

    // Quotient minus one, saturated to 16 bits; zero stays zero
    function automatic logic [CMP_W-1:0] sat16(input logic [DIVIDEND_W-1:0] q);
        logic [DIVIDEND_W-1:0] qm;
        qm = q - DIVIDEND_W'(1);
        if (q == '0) begin
            return '0;
        end
        if (qm > DIVIDEND_W'(16'hFFFF)) begin
            return 16'hFFFF;
        end
        return qm[CMP_W-1:0];
    endfunction

endpackage

// ----- design/cwsg_if.sv -----
// ---------------------------------------------------------------------------
// cwsg_if
// Valid/ready channels: the request stream and the status result stream.
// ---------------------------------------------------------------------------
interface cwsg_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  func;
    logic                        enc_a;
    logic                        enc_b;
    logic [cwsg_pkg::TIME_W-1:0] time_ms;

    modport source (output valid, func, enc_a, enc_b, time_ms, input ready);
    modport sink   (input valid, func, enc_a, enc_b, time_ms, output ready);
endinterface

interface cwsg_stat_if;
    logic                       valid;
    logic                       ready;
    logic                       crank_level;
    logic                       wheel_level;
    logic                       adjust_mode;
    logic [cwsg_pkg::RPM_W-1:0] engine_rpm;
    logic [cwsg_pkg::KMH_W-1:0] vehicle_kmh;

    modport source (output valid, crank_level, wheel_level, adjust_mode,
                    engine_rpm, vehicle_kmh, input ready);
    modport sink   (input valid, crank_level, wheel_level, adjust_mode,
                    engine_rpm, vehicle_kmh, output ready);
endinterface

// ----- design/crank_wheel_signal_generator_unit.sv -----
// ---------------------------------------------------------------------------
// crank_wheel_signal_generator_unit
// Every accepted request gives its status in the cycle after acceptance.
// Ticks, button presses and ignored events do not hold the request channel;
// an accepted encoder step blocks it in ST_LOAD and ST_DIV while the shared
// 34-step divider recomputes the compare value, in ST_LOAD only for a zero setpoint.
// Reset (async, active low) restores register defaults and stops both outputs.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module crank_wheel_signal_generator_unit #(
    parameter int RPM_PRESCALE       = 1,
    parameter int SPEED_PRESCALE     = 64,
    parameter int BUTTON_HOLDOFF_MS  = 200,
    parameter int ENCODER_HOLDOFF_MS = 5,
    parameter int PATTERN_LENGTH     = 120
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [cwsg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cwsg_pkg::CFG_DAT_W-1:0]   cfg_data,
    cwsg_req_if.sink                         cmd,
    cwsg_stat_if.source                      status
);
    import cwsg_pkg::*;

    localparam logic [PRE_W:0]       RPM_PRE    = (PRE_W+1)'(RPM_PRESCALE);
    localparam logic [PRE_W:0]       SPEED_PRE  = (PRE_W+1)'(SPEED_PRESCALE);
    localparam logic [DIVISOR_W-1:0] RPM_MUL    = DIVISOR_W'(2 * RPM_PRESCALE);
    localparam logic [TIME_W-1:0]    BTN_HOLD   = TIME_W'(BUTTON_HOLDOFF_MS);
    localparam logic [TIME_W-1:0]    ENC_HOLD   = TIME_W'(ENCODER_HOLDOFF_MS);
    localparam logic [IDX_W-1:0]     IDX_TOP    = IDX_W'(PATTERN_LENGTH - 1);
    localparam logic [IDX_W-1:0]     IDX_LEN    = IDX_W'(PATTERN_LENGTH);
    localparam logic [IDX_W-1:0]     PAT_TOTAL  = IDX_W'(2 * PAT_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV
    } state_t;

    state_t                state_reg, state_next;

    // Configuration
    logic [RSTEP_W-1:0]    rpm_step_reg, rpm_step_next;
    logic [RPM_W-1:0]      rpm_limit_reg, rpm_limit_next;
    logic [SSTEP_W-1:0]    speed_step_reg, speed_step_next;
    logic [KMH_W-1:0]      speed_limit_reg, speed_limit_next;
    logic [WCONST_W-1:0]   wheel_const_reg, wheel_const_next;
    logic [PAT_W-1:0]      pat_low_reg, pat_low_next;
    logic [PAT_W-1:0]      pat_high_reg, pat_high_next;

    // Generator state
    logic [RPM_W-1:0]      rpm_reg, rpm_next;
    logic [KMH_W-1:0]      kmh_reg, kmh_next;
    logic                  mode_reg, mode_next;
    logic                  pin_a_reg, pin_a_next;
    logic [1:0]            dir_reg, dir_next;
    logic [TIME_W-1:0]     last_btn_reg, last_btn_next;
    logic [TIME_W-1:0]     last_enc_reg, last_enc_next;
    logic [CMP_W-1:0]      rpm_cmp_reg, rpm_cmp_next;
    logic [CMP_W-1:0]      spd_cmp_reg, spd_cmp_next;
    logic [CMP_W-1:0]      rpm_tmr_reg, rpm_tmr_next;
    logic [CMP_W-1:0]      spd_tmr_reg, spd_tmr_next;
    logic [PRE_W-1:0]      rpm_pre_reg, rpm_pre_next;
    logic [PRE_W-1:0]      spd_pre_reg, spd_pre_next;
    logic [IDX_W-1:0]      crank_idx_reg, crank_idx_next;
    logic                  crank_reg, crank_next;
    logic                  wheel_reg, wheel_next;

    // Status output register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_crank_reg, out_crank_next;
    logic                  out_wheel_reg, out_wheel_next;
    logic                  out_mode_reg, out_mode_next;
    logic [RPM_W-1:0]      out_rpm_reg, out_rpm_next;
    logic [KMH_W-1:0]      out_kmh_reg, out_kmh_next;

    logic                  accept;
    logic                  enc_step;
    logic [2*PAT_W-1:0]    pat_vec;
    logic                  pat_bit;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    div_result_t           div_res;

    // Shared divider
    cwsg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .result   (div_res)
    );

    // Handshake
    assign cmd.ready = (state_reg == ST_IDLE) && (!out_valid_reg || status.ready);
    assign accept    = cmd.valid && cmd.ready;
    assign enc_step  = accept && (func_t'(cmd.func) == FUNC_ENCODER)
                       && ((cmd.time_ms - last_enc_reg) > ENC_HOLD);

    // Crank pattern lookup
    assign pat_vec = {pat_high_reg, pat_low_reg};
    assign pat_bit = (crank_idx_reg < PAT_TOTAL) ? pat_vec[crank_idx_reg] : 1'b0;

    // Divider operands from the adjusted channel
    always_comb
    begin
        if (mode_reg) begin
            div_dividend = DIVIDEND_W'({wheel_const_reg, 1'b0}) + DIVIDEND_W'(kmh_reg);
            div_divisor  = DIVISOR_W'({kmh_reg, 1'b0});
        end else begin
            div_dividend = CLOCK_HZ;
            div_divisor  = DIVISOR_W'(rpm_reg) * RPM_MUL;
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        rpm_step_next    = rpm_step_reg;
        rpm_limit_next   = rpm_limit_reg;
        speed_step_next  = speed_step_reg;
        speed_limit_next = speed_limit_reg;
        wheel_const_next = wheel_const_reg;
        pat_low_next     = pat_low_reg;
        pat_high_next    = pat_high_reg;
        rpm_next         = rpm_reg;
        kmh_next         = kmh_reg;
        mode_next        = mode_reg;
        pin_a_next       = pin_a_reg;
        dir_next         = dir_reg;
        last_btn_next    = last_btn_reg;
        last_enc_next    = last_enc_reg;
        rpm_cmp_next     = rpm_cmp_reg;
        spd_cmp_next     = spd_cmp_reg;
        rpm_tmr_next     = rpm_tmr_reg;
        spd_tmr_next     = spd_tmr_reg;
        rpm_pre_next     = rpm_pre_reg;
        spd_pre_next     = spd_pre_reg;
        crank_idx_next   = crank_idx_reg;
        crank_next       = crank_reg;
        wheel_next       = wheel_reg;
        div_start        = 1'b0;

        // Configuration writes
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_RPM_STEP:    rpm_step_next    = cfg_data[RSTEP_W-1:0];
                REG_RPM_LIMIT:   rpm_limit_next   = cfg_data[RPM_W-1:0];
                REG_SPEED_STEP:  speed_step_next  = cfg_data[SSTEP_W-1:0];
                REG_SPEED_LIMIT: speed_limit_next = cfg_data[KMH_W-1:0];
                REG_WHEEL_CONST: wheel_const_next = cfg_data[WCONST_W-1:0];
                REG_PAT_LOW:     pat_low_next     = cfg_data[PAT_W-1:0];
                REG_PAT_HIGH:    pat_high_next    = cfg_data[PAT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    case (func_t'(cmd.func))
                        FUNC_TICK:
                        begin
                            // Crank channel
                            if (rpm_cmp_reg != '0) begin
                                if ({1'b0, rpm_pre_reg} + (PRE_W+1)'(1) >= RPM_PRE) begin
                                    rpm_pre_next = '0;
                                    if (rpm_tmr_reg >= rpm_cmp_reg) begin
                                        rpm_tmr_next   = '0;
                                        crank_next     = pat_bit;
                                        crank_idx_next = (crank_idx_reg == '0
                                                          || crank_idx_reg >= IDX_LEN)
                                                         ? IDX_TOP
                                                         : crank_idx_reg - IDX_W'(1);
                                    end else begin
                                        rpm_tmr_next = rpm_tmr_reg + CMP_W'(1);
                                    end
                                end else begin
                                    rpm_pre_next = rpm_pre_reg + PRE_W'(1);
                                end
                            end
                            // Wheel channel
                            if (spd_cmp_reg != '0) begin
                                if ({1'b0, spd_pre_reg} + (PRE_W+1)'(1) >= SPEED_PRE) begin
                                    spd_pre_next = '0;
                                    if (spd_tmr_reg >= spd_cmp_reg) begin
                                        spd_tmr_next = '0;
                                        wheel_next   = ~wheel_reg;
                                    end else begin
                                        spd_tmr_next = spd_tmr_reg + CMP_W'(1);
                                    end
                                end else begin
                                    spd_pre_next = spd_pre_reg + PRE_W'(1);
                                end
                            end
                        end
                        FUNC_ENCODER:
                        begin
                            if (enc_step) begin
                                if (pin_a_reg && !cmd.enc_a) begin
                                    dir_next = cmd.enc_b ? DIR_UP : DIR_DOWN;
                                end
                                pin_a_next    = cmd.enc_a;
                                last_enc_next = cmd.time_ms;
                                if (mode_reg) begin
                                    kmh_next = KMH_W'(clamp_step(RPM_W'(kmh_reg),
                                                                 RSTEP_W'(speed_step_reg),
                                                                 dir_next,
                                                                 RPM_W'(speed_limit_reg)));
                                end else begin
                                    rpm_next = clamp_step(rpm_reg, rpm_step_reg,
                                                          dir_next, rpm_limit_reg);
                                end
                                state_next = ST_LOAD;
                            end
                        end
                        FUNC_BUTTON:
                        begin
                            if ((cmd.time_ms - last_btn_reg) > BTN_HOLD) begin
                                mode_next     = ~mode_reg;
                                last_btn_next = cmd.time_ms;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD:
            begin
                // A zero setpoint stops the channel without a division
                if ((mode_reg && kmh_reg == '0) || (!mode_reg && rpm_reg == '0)) begin
                    if (mode_reg) begin
                        spd_cmp_next = '0;
                    end else begin
                        rpm_cmp_next = '0;
                    end
                    state_next = ST_IDLE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_res.done) begin
                    if (mode_reg) begin
                        spd_cmp_next = sat16(div_res.quotient);
                    end else begin
                        rpm_cmp_next = sat16(div_res.quotient);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Status register: capture the state after each request
    always_comb
    begin
        out_valid_next = out_valid_reg && !status.ready;
        out_crank_next = out_crank_reg;
        out_wheel_next = out_wheel_reg;
        out_mode_next  = out_mode_reg;
        out_rpm_next   = out_rpm_reg;
        out_kmh_next   = out_kmh_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            out_crank_next = crank_next;
            out_wheel_next = wheel_next;
            out_mode_next  = mode_next;
            out_rpm_next   = rpm_next;
            out_kmh_next   = kmh_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            rpm_step_reg    <= RSTEP_W'(100);
            rpm_limit_reg   <= RPM_W'(8000);
            speed_step_reg  <= SSTEP_W'(1);
            speed_limit_reg <= KMH_W'(250);
            wheel_const_reg <= WCONST_W'(18750);
            pat_low_reg     <= '0;
            pat_high_reg    <= '0;
            rpm_reg         <= '0;
            kmh_reg         <= '0;
            mode_reg        <= 1'b0;
            pin_a_reg       <= 1'b0;
            dir_reg         <= DIR_NONE;
            last_btn_reg    <= '0;
            last_enc_reg    <= '0;
            rpm_cmp_reg     <= '0;
            spd_cmp_reg     <= '0;
            rpm_tmr_reg     <= '0;
            spd_tmr_reg     <= '0;
            rpm_pre_reg     <= '0;
            spd_pre_reg     <= '0;
            crank_idx_reg   <= IDX_TOP;
            crank_reg       <= 1'b0;
            wheel_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            rpm_step_reg    <= rpm_step_next;
            rpm_limit_reg   <= rpm_limit_next;
            speed_step_reg  <= speed_step_next;
            speed_limit_reg <= speed_limit_next;
            wheel_const_reg <= wheel_const_next;
            pat_low_reg     <= pat_low_next;
            pat_high_reg    <= pat_high_next;
            rpm_reg         <= rpm_next;
            kmh_reg         <= kmh_next;
            mode_reg        <= mode_next;
            pin_a_reg       <= pin_a_next;
            dir_reg         <= dir_next;
            last_btn_reg    <= last_btn_next;
            last_enc_reg    <= last_enc_next;
            rpm_cmp_reg     <= rpm_cmp_next;
            spd_cmp_reg     <= spd_cmp_next;
            rpm_tmr_reg     <= rpm_tmr_next;
            spd_tmr_reg     <= spd_tmr_next;
            rpm_pre_reg     <= rpm_pre_next;
            spd_pre_reg     <= spd_pre_next;
            crank_idx_reg   <= crank_idx_next;
            crank_reg       <= crank_next;
            wheel_reg       <= wheel_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Status payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_crank_reg <= out_crank_next;
        out_wheel_reg <= out_wheel_next;
        out_mode_reg  <= out_mode_next;
        out_rpm_reg   <= out_rpm_next;
        out_kmh_reg   <= out_kmh_next;
    end

    assign status.valid       = out_valid_reg;
    assign status.crank_level = out_crank_reg;
    assign status.wheel_level = out_wheel_reg;
    assign status.adjust_mode = out_mode_reg;
    assign status.engine_rpm  = out_rpm_reg;
    assign status.vehicle_kmh = out_kmh_reg;

    // Checks
    `CWSG_ASSERT(a_ready_idle, cmd.ready |-> (state_reg == ST_IDLE), "ready outside idle")
    `CWSG_ASSERT_NEXT(a_step_blocks, enc_step, !cmd.ready, "encoder step did not block requests")
    `CWSG_ASSERT(a_done_in_div, div_res.done |-> (state_reg == ST_DIV), "divider done out of sequence")
    `CWSG_ASSERT(a_idx_range, crank_idx_reg < IDX_LEN, "crank index out of pattern")

endmodule

// ----- design/cwsg_div.sv -----
// ---------------------------------------------------------------------------
// cwsg_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module cwsg_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [cwsg_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [cwsg_pkg::DIVISOR_W-1:0]    divisor,
    output cwsg_pkg::div_result_t             result
);
    import cwsg_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    // Shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        trial      = {rem_reg, dq_reg[DIVIDEND_W-1]};
        diff       = trial - {1'b0, dvs_reg};
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        dq_next    = dq_reg;
        if (start) begin
            count_next = CNT_W'(DIVIDEND_W);
            rem_next   = '0;
            dvs_next   = divisor;
            dq_next    = dividend;
        end else if (count_reg != '0) begin
            count_next = count_reg - CNT_W'(1);
            done_next  = (count_reg == CNT_W'(1));
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DIVISOR_W-1:0];
                dq_next  = {dq_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
                dq_next  = {dq_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dq_reg  <= dq_next;
    end

    assign result.done     = done_reg;
    assign result.quotient = dq_reg;

endmodule
